### hw/rtl/fnpll_pkg.sv
`default_nettype none

package fnpll_pkg;

  localparam int REF_W     = 29;
  localparam int FREQ_W    = 32;
  localparam int WORD_W    = 24;
  localparam int INT_W     = 16;
  localparam int FRAC_W    = 24;
  localparam int CODE_W    = 3;
  localparam int MAX_SHIFT = 6;
  localparam int DIVIDEND_W = FREQ_W + FRAC_W + MAX_SHIFT;
  localparam int QUOT_W    = INT_W + FRAC_W;
  localparam int DIV_STEPS = DIVIDEND_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PROD_W    = FRAC_W + REF_W;
  localparam int ACC_W     = INT_W + REF_W + 1;
  localparam int IDX_W     = 3;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(10000000);

  localparam logic [FREQ_W-1:0] THR_DIV1  = 32'd1500000000;
  localparam logic [FREQ_W-1:0] THR_DIV2  = 32'd750000000;
  localparam logic [FREQ_W-1:0] THR_DIV4  = 32'd375000000;
  localparam logic [FREQ_W-1:0] THR_DIV8  = 32'd187500000;
  localparam logic [FREQ_W-1:0] THR_DIV16 = 32'd93750000;
  localparam logic [FREQ_W-1:0] THR_DIV32 = 32'd46875000;

  // fixed register words
  localparam logic [WORD_W-1:0] WORD_R2 = 24'hA00002;
  localparam logic [WORD_W-1:0] WORD_R3 = 24'h000453;
  localparam logic [WORD_W-1:0] WORD_R5 = 24'h400005;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_FREQ = 1'b1;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_INIT = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    W_R0,
    W_R1,
    W_R2,
    W_R3,
    W_R4,
    W_R5,
    W_FREQ
  } word_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_MUL_F,
    S_MUL_I,
    S_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic      div_init;
    logic      div_step;
    logic      div_store;
    logic      mul_frac;
    logic      mul_int;
    logic      mul_add;
    logic      emit;
    word_sel_t word;
    logic      last;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/fnpll_req_if.sv
`default_nettype none

interface fnpll_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] target_hz;

  modport source (output valid, output command, output target_hz, input ready);
  modport sink   (input valid, input command, input target_hz, output ready);
endinterface

`default_nettype wire

### hw/rtl/fnpll_rsp_if.sv
`default_nettype none

interface fnpll_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] reg_word;
  logic [31:0] freq_readback;
  logic        kind;
  logic        last;

  modport source (output valid, output reg_word, output freq_readback, output kind,
                  output last, input ready);
  modport sink   (input valid, input reg_word, input freq_readback, input kind,
                  input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/fnpll_ctrl.sv
`default_nettype none

module fnpll_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [1:0]          req_command,
  input  logic                out_free,
  output fnpll_pkg::ctrl_cmd_t ctl
);

  fnpll_pkg::state_t                   state, state_next;
  fnpll_pkg::cmd_t                     cmd_q, cmd_q_next;
  logic [fnpll_pkg::STEP_W-1:0]        step_cnt, step_cnt_next;
  logic [fnpll_pkg::IDX_W-1:0]         idx, idx_next;
  fnpll_pkg::word_sel_t                seq_word;
  logic                                seq_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fnpll_pkg::S_IDLE;
      cmd_q    <= fnpll_pkg::CMD_NOP;
      step_cnt <= '0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      cmd_q    <= cmd_q_next;
      step_cnt <= step_cnt_next;
      idx      <= idx_next;
    end
  end

  // output word order per command
  always_comb begin
    seq_word = fnpll_pkg::W_FREQ;
    seq_last = 1'b1;
    unique case (cmd_q)
      fnpll_pkg::CMD_SET: begin
        unique case (idx)
          3'd0:    begin seq_word = fnpll_pkg::W_R4; seq_last = 1'b0; end
          3'd1:    begin seq_word = fnpll_pkg::W_R1; seq_last = 1'b0; end
          default: begin seq_word = fnpll_pkg::W_R0; seq_last = 1'b1; end
        endcase
      end
      fnpll_pkg::CMD_INIT: begin
        unique case (idx)
          3'd0:    begin seq_word = fnpll_pkg::W_R5; seq_last = 1'b0; end
          3'd1:    begin seq_word = fnpll_pkg::W_R4; seq_last = 1'b0; end
          3'd2:    begin seq_word = fnpll_pkg::W_R3; seq_last = 1'b0; end
          3'd3:    begin seq_word = fnpll_pkg::W_R2; seq_last = 1'b0; end
          3'd4:    begin seq_word = fnpll_pkg::W_R1; seq_last = 1'b0; end
          default: begin seq_word = fnpll_pkg::W_R0; seq_last = 1'b1; end
        endcase
      end
      fnpll_pkg::CMD_READ: begin
        seq_word = fnpll_pkg::W_FREQ;
        seq_last = 1'b1;
      end
      fnpll_pkg::CMD_NOP: begin
        seq_word = fnpll_pkg::W_FREQ;
        seq_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    cmd_q_next    = cmd_q;
    step_cnt_next = step_cnt;
    idx_next      = idx;
    req_ready     = 1'b0;
    ctl           = '0;
    ctl.word      = seq_word;
    ctl.last      = seq_last;
    unique case (state)
      fnpll_pkg::S_IDLE: begin
        req_ready     = 1'b1;
        step_cnt_next = '0;
        idx_next      = '0;
        if (req_valid) begin
          cmd_q_next = fnpll_pkg::cmd_t'(req_command);
          unique case (fnpll_pkg::cmd_t'(req_command))
            fnpll_pkg::CMD_SET: begin
              ctl.div_init = 1'b1;
              state_next   = fnpll_pkg::S_DIV;
            end
            fnpll_pkg::CMD_INIT: state_next = fnpll_pkg::S_EMIT;
            fnpll_pkg::CMD_READ: state_next = fnpll_pkg::S_MUL_F;
            fnpll_pkg::CMD_NOP:  state_next = fnpll_pkg::S_IDLE;
          endcase
        end
      end
      fnpll_pkg::S_DIV: begin
        ctl.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == fnpll_pkg::STEP_W'(fnpll_pkg::DIV_STEPS - 1)) begin
          state_next = fnpll_pkg::S_STORE;
        end
      end
      fnpll_pkg::S_STORE: begin
        ctl.div_store = 1'b1;
        state_next    = fnpll_pkg::S_EMIT;
      end
      fnpll_pkg::S_MUL_F: begin
        ctl.mul_frac = 1'b1;
        state_next   = fnpll_pkg::S_MUL_I;
      end
      fnpll_pkg::S_MUL_I: begin
        ctl.mul_int = 1'b1;
        state_next  = fnpll_pkg::S_ADD;
      end
      fnpll_pkg::S_ADD: begin
        ctl.mul_add = 1'b1;
        state_next  = fnpll_pkg::S_EMIT;
      end
      fnpll_pkg::S_EMIT: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (seq_last) begin
            state_next = fnpll_pkg::S_IDLE;
          end
        end
      end
      default: state_next = fnpll_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/fnpll_dp.sv
`default_nettype none

module fnpll_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  fnpll_pkg::ctrl_cmd_t          ctl,
  input  logic [fnpll_pkg::FREQ_W-1:0]  target_hz,
  input  logic                          cfg_we,
  input  logic [fnpll_pkg::REF_W-1:0]   cfg_data,
  input  logic                          out_ready,
  output logic                          out_free,
  output logic                          out_valid,
  output logic [fnpll_pkg::WORD_W-1:0]  reg_word,
  output logic [fnpll_pkg::FREQ_W-1:0]  freq_readback,
  output logic                          kind,
  output logic                          last
);

  logic [fnpll_pkg::REF_W-1:0]      ref_clock_hz;
  logic [fnpll_pkg::INT_W-1:0]      int_part;
  logic [fnpll_pkg::FRAC_W-1:0]     frac_part;
  logic [fnpll_pkg::CODE_W-1:0]     out_div_code;

  logic [fnpll_pkg::DIVIDEND_W-1:0] dividend;
  logic [fnpll_pkg::REF_W-1:0]      rem;
  logic [fnpll_pkg::QUOT_W-1:0]     quot;
  logic [fnpll_pkg::PROD_W-1:0]     prod;
  logic [fnpll_pkg::ACC_W-1:0]      acc;

  logic [fnpll_pkg::CODE_W-1:0]     code_new;
  logic [fnpll_pkg::DIVIDEND_W-1:0] dividend_init;
  logic [fnpll_pkg::REF_W:0]        trial;
  logic [fnpll_pkg::REF_W:0]        trial_sub;
  logic                             trial_ge;
  logic [fnpll_pkg::FRAC_W-1:0]     mul_a;
  logic [fnpll_pkg::PROD_W-1:0]     mul_p;
  logic [fnpll_pkg::ACC_W-1:0]      acc_shr;

  always_comb begin
    priority if (target_hz >= fnpll_pkg::THR_DIV1)  code_new = 3'd0;
    else if (target_hz >= fnpll_pkg::THR_DIV2)      code_new = 3'd1;
    else if (target_hz >= fnpll_pkg::THR_DIV4)      code_new = 3'd2;
    else if (target_hz >= fnpll_pkg::THR_DIV8)      code_new = 3'd3;
    else if (target_hz >= fnpll_pkg::THR_DIV16)     code_new = 3'd4;
    else if (target_hz >= fnpll_pkg::THR_DIV32)     code_new = 3'd5;
    else                                            code_new = 3'd6;
  end

  assign dividend_init = {{fnpll_pkg::MAX_SHIFT{1'b0}}, target_hz,
                          {fnpll_pkg::FRAC_W{1'b0}}} << code_new;

  // restoring divide, one dividend bit per cycle; a zero reference gives all ones
  assign trial     = {rem, dividend[fnpll_pkg::DIVIDEND_W-1]};
  assign trial_ge  = (trial >= {1'b0, ref_clock_hz});
  assign trial_sub = trial - {1'b0, ref_clock_hz};

  assign mul_a = ctl.mul_int ? {{(fnpll_pkg::FRAC_W - fnpll_pkg::INT_W){1'b0}}, int_part}
                             : frac_part;
  assign mul_p = {{fnpll_pkg::REF_W{1'b0}}, mul_a} * {{fnpll_pkg::FRAC_W{1'b0}}, ref_clock_hz};

  assign acc_shr = acc >> out_div_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz <= fnpll_pkg::REF_RESET;
      int_part     <= '0;
      frac_part    <= '0;
      out_div_code <= '0;
    end else begin
      if (cfg_we) begin
        ref_clock_hz <= cfg_data;
      end
      if (ctl.div_init) begin
        out_div_code <= code_new;
      end
      if (ctl.div_store) begin
        int_part  <= quot[fnpll_pkg::QUOT_W-1:fnpll_pkg::FRAC_W];
        frac_part <= quot[fnpll_pkg::FRAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      dividend <= dividend_init;
      rem      <= '0;
      quot     <= '0;
    end else if (ctl.div_step) begin
      dividend <= {dividend[fnpll_pkg::DIVIDEND_W-2:0], 1'b0};
      rem      <= trial_ge ? trial_sub[fnpll_pkg::REF_W-1:0] : trial[fnpll_pkg::REF_W-1:0];
      quot     <= {quot[fnpll_pkg::QUOT_W-2:0], trial_ge};
    end
  end

  // readback: frac*ref, then int*ref with (frac*ref)>>24, then sum
  always_ff @(posedge clk) begin
    if (ctl.mul_frac || ctl.mul_int) begin
      prod <= mul_p;
    end
    if (ctl.mul_int) begin
      acc <= {{(fnpll_pkg::ACC_W - fnpll_pkg::REF_W){1'b0}},
              prod[fnpll_pkg::PROD_W-1:fnpll_pkg::FRAC_W]};
    end else if (ctl.mul_add) begin
      acc <= acc + prod[fnpll_pkg::ACC_W-1:0];
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      last          <= ctl.last;
      kind          <= fnpll_pkg::KIND_WORD;
      freq_readback <= '0;
      unique case (ctl.word)
        fnpll_pkg::W_R0: reg_word <= {int_part, 8'h00};
        fnpll_pkg::W_R1: reg_word <= {frac_part[fnpll_pkg::WORD_W-5:0], 4'h1};
        fnpll_pkg::W_R2: reg_word <= fnpll_pkg::WORD_R2;
        fnpll_pkg::W_R3: reg_word <= fnpll_pkg::WORD_R3;
        fnpll_pkg::W_R4: reg_word <= {1'b0, out_div_code, 20'h00004};
        fnpll_pkg::W_R5: reg_word <= fnpll_pkg::WORD_R5;
        fnpll_pkg::W_FREQ: begin
          reg_word      <= '0;
          kind          <= fnpll_pkg::KIND_FREQ;
          freq_readback <= acc_shr[fnpll_pkg::FREQ_W-1:0];
        end
        default: reg_word <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frac_n_pll_divider_programmer.sv
// Fractional-N PLL divider programmer.
// req channel: one item = command (set / init / readback / nop) and target_hz.
// rsp channel: 24-bit register words (kind 0) or a rebuilt frequency (kind 1),
// with last marking the final result of an item. cfg_we/cfg_data write the
// reference clock in hertz; the user must do so only while the block is idle,
// as the block does not enforce it. Set: a restoring divider takes one
// dividend bit per cycle over 62 bits, then R4, R1 and R0 follow one per
// cycle while rsp is not stalled. Init: words R5..R0 in that order.
// Readback: one shared 24x29 multiplier used twice plus an add, run through
// the states S_MUL_F, S_MUL_I and S_ADD.
// One item is worked on at a time; the next is accepted once the last result
// of the previous one sits in the output register.
// A stalled rsp holds the output register; the sequencer waits on it.
// Reset (synchronous, active high) sets the reference to 10 MHz and clears
// the stored integer part, fraction and output divider code.
`default_nettype none

module frac_n_pll_divider_programmer (
  input  logic                         clk,
  input  logic                         rst,
  fnpll_req_if.sink                    req,
  fnpll_rsp_if.source                  rsp,
  input  logic                         cfg_we,
  input  logic [fnpll_pkg::REF_W-1:0]  cfg_data
);

  fnpll_pkg::ctrl_cmd_t ctl;
  logic                 out_free;

  fnpll_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.command),
    .out_free    (out_free),
    .ctl         (ctl)
  );

  fnpll_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .target_hz     (req.target_hz),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_ready     (rsp.ready),
    .out_free      (out_free),
    .out_valid     (rsp.valid),
    .reg_word      (rsp.reg_word),
    .freq_readback (rsp.freq_readback),
    .kind          (rsp.kind),
    .last          (rsp.last)
  );

endmodule

`default_nettype wire

### verif/frac_n_pll_divider_programmer_test.sv
`timescale 1ns / 1ps

module frac_n_pll_divider_programmer_test;

  typedef struct packed {
    logic [fnpll_pkg::WORD_W-1:0] word;
    logic [fnpll_pkg::FREQ_W-1:0] freq;
    logic                         kind;
    logic                         last;
  } pll_result_t;

  localparam logic [fnpll_pkg::WORD_W-1:0] R2_FIXED =
    (24'd1 << 23) | (24'd1 << 21) | 24'd2;
  localparam logic [fnpll_pkg::WORD_W-1:0] R3_FIXED = (24'd2 << 9) | (24'd5 << 4) | 24'd3;
  localparam logic [fnpll_pkg::WORD_W-1:0] R5_FIXED = (24'd1 << 22) | 24'd5;
  localparam logic [fnpll_pkg::REF_W-1:0]  REF_AFTER_RESET = 29'd10000000;
  // quiet time after the last due result; covers a trailing ignored command too
  localparam int SETTLE_CYCLES = 80;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [fnpll_pkg::REF_W-1:0] cfg_data;

  fnpll_req_if req_if();
  fnpll_rsp_if rsp_if();

  frac_n_pll_divider_programmer dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [fnpll_pkg::REF_W-1:0]  ref_hz = REF_AFTER_RESET;
  logic [fnpll_pkg::INT_W-1:0]  pll_int = '0;
  logic [fnpll_pkg::FRAC_W-1:0] pll_frac = '0;
  logic [fnpll_pkg::CODE_W-1:0] pll_div_code = '0;

  pll_result_t due_results[$];
  int failures = 0;
  int send_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void push_result(logic [fnpll_pkg::WORD_W-1:0] word,
                                      logic [fnpll_pkg::FREQ_W-1:0] freq,
                                      logic kind, logic last);
    pll_result_t r;
    r.word = word;
    r.freq = freq;
    r.kind = kind;
    r.last = last;
    due_results.push_back(r);
  endfunction

  function automatic void push_word(logic [fnpll_pkg::WORD_W-1:0] word, logic last);
    push_result(word, '0, fnpll_pkg::KIND_WORD, last);
  endfunction

  function automatic logic [fnpll_pkg::WORD_W-1:0] r0_word();
    return {pll_int, 8'h00};
  endfunction

  function automatic logic [fnpll_pkg::WORD_W-1:0] r1_word();
    return {pll_frac[fnpll_pkg::FRAC_W-5:0], 4'h1};
  endfunction

  function automatic logic [fnpll_pkg::WORD_W-1:0] r4_word();
    return {1'b0, pll_div_code, 20'h00004};
  endfunction

  function automatic void predict_command(fnpll_pkg::cmd_t cmd,
                                          logic [fnpll_pkg::FREQ_W-1:0] hz);
    logic [63:0] scaled;
    logic [63:0] n;
    logic [63:0] vco;
    case (cmd)
      fnpll_pkg::CMD_SET: begin
        if (hz >= fnpll_pkg::THR_DIV1) pll_div_code = 3'd0;
        else if (hz >= fnpll_pkg::THR_DIV2) pll_div_code = 3'd1;
        else if (hz >= fnpll_pkg::THR_DIV4) pll_div_code = 3'd2;
        else if (hz >= fnpll_pkg::THR_DIV8) pll_div_code = 3'd3;
        else if (hz >= fnpll_pkg::THR_DIV16) pll_div_code = 3'd4;
        else if (hz >= fnpll_pkg::THR_DIV32) pll_div_code = 3'd5;
        else pll_div_code = 3'd6;
        if (ref_hz == '0) begin
          // divider by zero answers all ones
          pll_int = '1;
          pll_frac = '1;
        end else begin
          scaled = 64'(hz) << (pll_div_code + fnpll_pkg::FRAC_W);
          n = scaled / 64'(ref_hz);
          pll_int = n[fnpll_pkg::FRAC_W +: fnpll_pkg::INT_W];
          pll_frac = n[fnpll_pkg::FRAC_W-1:0];
        end
        push_word(r4_word(), 1'b0);
        push_word(r1_word(), 1'b0);
        push_word(r0_word(), 1'b1);
      end
      fnpll_pkg::CMD_INIT: begin
        push_word(R5_FIXED, 1'b0);
        push_word(r4_word(), 1'b0);
        push_word(R3_FIXED, 1'b0);
        push_word(R2_FIXED, 1'b0);
        push_word(r1_word(), 1'b0);
        push_word(r0_word(), 1'b1);
      end
      fnpll_pkg::CMD_READ: begin
        vco = 64'(pll_int) * 64'(ref_hz) +
              ((64'(pll_frac) * 64'(ref_hz)) >> fnpll_pkg::FRAC_W);
        push_result('0, 32'(vco >> pll_div_code), fnpll_pkg::KIND_FREQ, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(fnpll_pkg::cmd_t cmd, logic [fnpll_pkg::FREQ_W-1:0] hz);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.target_hz <= hz;
    do @(posedge clk); while (!req_if.ready);
    predict_command(cmd, hz);
  endtask

  // stop offering, wait for every due result, then let the block go quiet
  task automatic settle();
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ref(logic [fnpll_pkg::REF_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_hz = value;
  endtask

  function automatic logic [fnpll_pkg::FREQ_W-1:0] random_target();
    logic [fnpll_pkg::FREQ_W-1:0] band;
    case ($urandom_range(5))
      0: band = fnpll_pkg::THR_DIV1;
      1: band = fnpll_pkg::THR_DIV2;
      2: band = fnpll_pkg::THR_DIV4;
      3: band = fnpll_pkg::THR_DIV8;
      4: band = fnpll_pkg::THR_DIV16;
      default: band = fnpll_pkg::THR_DIV32;
    endcase
    case ($urandom_range(4))
      0: return $urandom;
      1: return band + $urandom_range(8) - 32'd4;
      2: return $urandom_range(fnpll_pkg::THR_DIV1, fnpll_pkg::THR_DIV32);
      3: return $urandom_range(fnpll_pkg::THR_DIV32);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic test_reset_state();
    send_request(fnpll_pkg::CMD_READ, '0);
    send_request(fnpll_pkg::CMD_INIT, '1);
  endtask

  // each band edge, just below the lowest and highest ones, all ones and zero
  task automatic test_divider_bands();
    logic [fnpll_pkg::FREQ_W-1:0] targets [10];
    targets = '{32'hFFFF_FFFF, fnpll_pkg::THR_DIV1, fnpll_pkg::THR_DIV1 - 1,
                fnpll_pkg::THR_DIV2, fnpll_pkg::THR_DIV4, fnpll_pkg::THR_DIV8,
                fnpll_pkg::THR_DIV16, fnpll_pkg::THR_DIV32, fnpll_pkg::THR_DIV32 - 1,
                32'd0};
    foreach (targets[i]) begin
      send_request(fnpll_pkg::CMD_SET, targets[i]);
      send_request(fnpll_pkg::CMD_READ, $urandom);
    end
  endtask

  task automatic test_ignored_command();
    send_request(fnpll_pkg::CMD_NOP, '1);
    send_request(fnpll_pkg::CMD_NOP, '0);
    send_request(fnpll_pkg::CMD_READ, '0);
  endtask

  // tiny references push N past 16 integer bits; the last case uses the largest reference
  task automatic test_wide_integer();
    settle();
    write_ref(29'd1);
    send_request(fnpll_pkg::CMD_SET, '1);
    send_request(fnpll_pkg::CMD_READ, '0);
    settle();
    write_ref(29'd1000);
    send_request(fnpll_pkg::CMD_SET, 32'd123456789);
    send_request(fnpll_pkg::CMD_INIT, '0);
    settle();
    write_ref('1);
    send_request(fnpll_pkg::CMD_SET, 32'd46874999);
    send_request(fnpll_pkg::CMD_READ, '0);
  endtask

  task automatic test_zero_reference();
    settle();
    write_ref('0);
    send_request(fnpll_pkg::CMD_SET, 32'd500000000);
    send_request(fnpll_pkg::CMD_INIT, '0);
    send_request(fnpll_pkg::CMD_READ, '0);
  endtask

  task automatic test_output_backpressure();
    settle();
    send_idle_pct = 0;
    rcv_idle_pct = 30;
    hold_left = 400;
    repeat (3) send_request(fnpll_pkg::CMD_INIT, '0);
    send_request(fnpll_pkg::CMD_SET, random_target());
    send_request(fnpll_pkg::CMD_READ, '0);
    send_request(fnpll_pkg::CMD_SET, random_target());
    repeat (2) send_request(fnpll_pkg::CMD_READ, '0);
    settle();
  endtask

  task automatic test_random_traffic(int count, int sidle, int ridle,
                                     logic [fnpll_pkg::REF_W-1:0] ref_value);
    int pick;
    fnpll_pkg::cmd_t cmd;
    settle();
    write_ref(ref_value);
    send_idle_pct = sidle;
    rcv_idle_pct = ridle;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 50) cmd = fnpll_pkg::CMD_SET;
      else if (pick < 72) cmd = fnpll_pkg::CMD_READ;
      else if (pick < 94) cmd = fnpll_pkg::CMD_INIT;
      else cmd = fnpll_pkg::CMD_NOP;
      send_request(cmd, random_target());
    end
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    pll_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (due_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual word %h freq %h kind %b last %b",
                 $time, rsp_if.reg_word, rsp_if.freq_readback, rsp_if.kind, rsp_if.last);
      end else begin
        want = due_results.pop_front();
        check_field("reg_word", 32'(want.word), 32'(rsp_if.reg_word));
        check_field("freq_readback", want.freq, rsp_if.freq_readback);
        check_field("kind", 32'(want.kind), 32'(rsp_if.kind));
        check_field("last", 32'(want.last), 32'(rsp_if.last));
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req_if.valid <= 1'b0;
    req_if.command <= fnpll_pkg::CMD_SET;
    req_if.target_hz <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    rcv_idle_pct = 20;

    test_reset_state();
    test_divider_bands();
    test_ignored_command();
    test_wide_integer();
    test_zero_reference();
    test_output_backpressure();
    test_random_traffic(40, 17, 82, 29'd300000000);
    test_random_traffic(40, 82, 17, 29'($urandom_range(300000000, 1000000)));
    test_random_traffic(38, 0, 0, 29'd1000000);
    settle();

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
hw/rtl/fnpll_pkg.sv
hw/rtl/fnpll_req_if.sv
hw/rtl/fnpll_rsp_if.sv
hw/rtl/fnpll_ctrl.sv
hw/rtl/fnpll_dp.sv
hw/rtl/frac_n_pll_divider_programmer.sv
verif/frac_n_pll_divider_programmer_test.sv
